// File: hdl/frmix_pkg.sv
// Package for the fold-and-replace mixer: shared item type, constants and the fold functions.
// Used by frmix_front, frmix_fifo, frmix_round and fold_replace_mixer.
// No dependencies.
package frmix_pkg;

    localparam int ROUNDS_DEF  = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] CUBIC_COEF = 64'd486662;
    localparam logic [15:0] FOLD_LIMIT = 16'd255;

    typedef struct packed {
        logic [63:0] value;
        logic        mode;
        logic        need;
    } item_t;

    function automatic logic [15:0] fold16(input logic [63:0] v);
        fold16 = v[63:48] ^ v[47:32] ^ v[31:16] ^ v[15:0];
    endfunction

    function automatic logic fold_low(input logic [63:0] v);
        fold_low = (fold16(v) < FOLD_LIMIT);
    endfunction

endpackage

// File: hdl/frmix_front.sv
// Front end of the mixer: input register, helper mode register and first-round classification.
// Depends on frmix_pkg.
// Pushes classified requests into the queue ahead of the round pipeline.
module frmix_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        seed_value,
    input  logic               helper_mode_we,
    input  logic               helper_mode_data,
    input  logic               full,
    output logic               push,
    output frmix_pkg::item_t   push_item
);

    logic             mode_reg;
    logic             valid_reg;
    logic             valid_next;
    frmix_pkg::item_t item_reg;
    logic             accept;

    assign push      = valid_reg && !full;
    assign in_stall  = valid_reg && full;
    assign accept    = in_valid && !in_stall;
    assign push_item = item_reg;

    assign valid_next = accept || (valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (helper_mode_we)
            begin
                mode_reg <= helper_mode_data;
            end
            valid_reg <= valid_next;
        end
    end

    // classify: tag mode and whether the first round applies the helper
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.value <= seed_value;
            item_reg.mode  <= mode_reg;
            item_reg.need  <= frmix_pkg::fold_low(seed_value);
        end
    end

endmodule

// File: hdl/frmix_fifo.sv
// Short request queue between the mixer front end and the round pipeline.
// Depends on frmix_pkg for the item type and depth.
// Head entry is presented directly on the pop side.
module frmix_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  frmix_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output frmix_pkg::item_t pop_item
);

    localparam int DEPTH = frmix_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    frmix_pkg::item_t entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/frmix_round.sv
// One pipelined fold-and-replace round: cubic helper as two 64-bit low-half products
// built from 32-bit partial products, then fold, shift and next-round classification.
// Depends on frmix_pkg. Six stages, all advancing on en.
module frmix_round
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  frmix_pkg::item_t in_item,
    output logic             out_valid,
    output frmix_pkg::item_t out_item
);

    logic [5:0]       vld_reg;

    // stage 1: value, cubic select, x + coef
    logic [63:0]      v1_reg;
    logic             use1_reg;
    logic             mode1_reg;
    logic [63:0]      a1_reg;

    // stage 2: partials of x * (x + coef)
    logic [63:0]      v2_reg;
    logic             use2_reg;
    logic             mode2_reg;
    logic [63:0]      p0_2_reg;
    logic [31:0]      p1_2_reg;
    logic [31:0]      p2_2_reg;
    logic [31:0]      p1_2_next;
    logic [31:0]      p2_2_next;

    // stage 3: t = x * (x + coef) + 1
    logic [63:0]      v3_reg;
    logic             use3_reg;
    logic             mode3_reg;
    logic [63:0]      t3_reg;
    logic [31:0]      cross3;

    // stage 4: partials of x * t
    logic [63:0]      v4_reg;
    logic             use4_reg;
    logic             mode4_reg;
    logic [63:0]      q0_4_reg;
    logic [31:0]      q1_4_reg;
    logic [31:0]      q2_4_reg;
    logic [31:0]      q1_4_next;
    logic [31:0]      q2_4_next;

    // stage 5: helper result
    logic [63:0]      y5_reg;
    logic             mode5_reg;
    logic [31:0]      cross5;
    logic [63:0]      cubic5;

    // stage 6: fold, shift, classify
    frmix_pkg::item_t item6_reg;
    logic [63:0]      shifted6;

    assign p1_2_next = v1_reg[31:0] * a1_reg[63:32];
    assign p2_2_next = v1_reg[63:32] * a1_reg[31:0];
    assign cross3    = p1_2_reg + p2_2_reg;
    assign q1_4_next = v3_reg[31:0] * t3_reg[63:32];
    assign q2_4_next = v3_reg[63:32] * t3_reg[31:0];
    assign cross5    = q1_4_reg + q2_4_reg;
    assign cubic5    = q0_4_reg + {cross5, 32'd0};
    assign shifted6  = {frmix_pkg::fold16(y5_reg), y5_reg[63:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg    <= in_item.value;
            use1_reg  <= in_item.need && in_item.mode;
            mode1_reg <= in_item.mode;
            a1_reg    <= in_item.value + frmix_pkg::CUBIC_COEF;

            v2_reg    <= v1_reg;
            use2_reg  <= use1_reg;
            mode2_reg <= mode1_reg;
            p0_2_reg  <= 64'(v1_reg[31:0]) * 64'(a1_reg[31:0]);
            p1_2_reg  <= p1_2_next;
            p2_2_reg  <= p2_2_next;

            v3_reg    <= v2_reg;
            use3_reg  <= use2_reg;
            mode3_reg <= mode2_reg;
            t3_reg    <= p0_2_reg + {cross3, 32'd0} + 64'd1;

            v4_reg    <= v3_reg;
            use4_reg  <= use3_reg;
            mode4_reg <= mode3_reg;
            q0_4_reg  <= 64'(v3_reg[31:0]) * 64'(t3_reg[31:0]);
            q1_4_reg  <= q1_4_next;
            q2_4_reg  <= q2_4_next;

            y5_reg    <= use4_reg ? cubic5 : v4_reg;
            mode5_reg <= mode4_reg;

            item6_reg.value <= shifted6;
            item6_reg.mode  <= mode5_reg;
            item6_reg.need  <= frmix_pkg::fold_low(shifted6);
        end
    end

    assign out_valid = vld_reg[5];
    assign out_item  = item6_reg;

endmodule

// File: hdl/fold_replace_mixer.sv
// Top level of the fold-and-replace mixer: front end, request queue and round pipeline.
// Depends on frmix_pkg, frmix_front, frmix_fifo and frmix_round.
//
// Usage:
//   Input channel: seed_value with in_valid / in_stall; a request is taken at a rising
//   edge with in_valid high and in_stall low. Output channel: mixed_value with
//   out_valid / out_stall, taken the same way.
//   helper_mode_we writes helper_mode_data (0 identity, 1 cubic helper); write it only
//   while no request is in flight. The mode is sampled when a request is taken.
// Pipeline: from acceptance to out_valid a request passes the input register, the queue,
//   then six stages per round, each 64-bit product split into 32-bit partial products
//   over two stages.
// Throughput: one request per cycle while out_stall is low; every round stage is fully pipelined.
// Stall: out_stall freezes the round pipeline; the final stage holds the result.
//   The queue and input register absorb requests until full, then in_stall rises.
// Reset: rst_n clears the mode to identity and empties the pipeline and queue.
module fold_replace_mixer
#(
    parameter int ROUNDS = frmix_pkg::ROUNDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] seed_value,
    input  logic        helper_mode_we,
    input  logic        helper_mode_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] mixed_value
);

    logic             push;
    logic             full;
    logic             empty;
    logic             adv;
    frmix_pkg::item_t push_item;
    frmix_pkg::item_t pop_item;

    logic             stage_valid [ROUNDS + 1];
    frmix_pkg::item_t stage_item  [ROUNDS + 1];

    frmix_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .seed_value       (seed_value),
        .helper_mode_we   (helper_mode_we),
        .helper_mode_data (helper_mode_data),
        .full             (full),
        .push             (push),
        .push_item        (push_item)
    );

    frmix_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (adv),
        .empty     (empty),
        .pop_item  (pop_item)
    );

    // advance the whole back end whenever the result slot is free or taken
    assign adv = !stage_valid[ROUNDS] || !out_stall;

    assign stage_valid[0] = !empty;
    assign stage_item[0]  = pop_item;

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        frmix_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (stage_valid[r]),
            .in_item   (stage_item[r]),
            .out_valid (stage_valid[r + 1]),
            .out_item  (stage_item[r + 1])
        );
    end

    assign out_valid   = stage_valid[ROUNDS];
    assign mixed_value = stage_item[ROUNDS].value;

endmodule

// File: verif/fold_replace_mixer_test.sv
// Testbench for fold_replace_mixer: a directed table, then random seeds over both helper modes.
// Each request is checked against its table result or a local four-round fold-and-replace predictor.
// Depends on fold_replace_mixer and frmix_pkg from hdl.
`timescale 1ns / 1ps

module fold_replace_mixer_test;

    localparam int          ROUND_COUNT   = 4;
    localparam logic [63:0] CUBIC_TERM    = 64'd486662;
    localparam logic [15:0] FOLD_FLOOR    = 16'd255;
    localparam int          PIPE_LATENCY  = 2 + 6 * ROUND_COUNT;
    localparam int          DIRECTED_ROWS = 21;
    localparam int          PHASE_COUNT   = 5;
    localparam int          PHASE_ITEMS   = 100;
    localparam int          HOLD_CYCLES   = 200;

    typedef enum logic { HELPER_IDENTITY = 1'b0, HELPER_CUBIC = 1'b1 } helper_sel_t;

    typedef struct {
        helper_sel_t mode;
        logic [63:0] seed;
        bit          known;
        logic [63:0] result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] seed_value;
    logic        helper_mode_we;
    logic        helper_mode_data;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] mixed_value;

    logic [63:0] expected_mix [$];
    stim_row_t   directed_rows [DIRECTED_ROWS];
    helper_sel_t cur_helper;
    int          fail_count;
    int          items_taken;
    int          results_seen;
    int          mode_writes;
    bit          steady;
    bit          pressure_pending;

    fold_replace_mixer #(.ROUNDS(ROUND_COUNT)) dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .seed_value       (seed_value),
        .helper_mode_we   (helper_mode_we),
        .helper_mode_data (helper_mode_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mixed_value      (mixed_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] xor_quarters(input logic [63:0] v);
        return v[63:48] ^ v[47:32] ^ v[31:16] ^ v[15:0];
    endfunction

    function automatic logic [63:0] mix_seed(input logic [63:0] seed, input helper_sel_t mode);
        logic [63:0] v;
        logic [15:0] f;
        v = seed;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            f = xor_quarters(v);
            if (f < FOLD_FLOOR)
            begin
                if (mode == HELPER_CUBIC)
                    v = v * v * v + CUBIC_TERM * v * v + v;
                f = xor_quarters(v);
            end
            v = {f, v[63:16]};
        end
        return v;
    endfunction

    task automatic note_failure(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // call at a falling edge; returns at a falling edge
    task automatic send_seed(input logic [63:0] seed, input bit known, input logic [63:0] want);
        while (!steady && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        seed_value <= seed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_mix.push_back(known ? want : mix_seed(seed, cur_helper));
        items_taken++;
        @(negedge clk);
    endtask

    task automatic settle_and_select(input helper_sel_t mode);
        in_valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        helper_mode_we   <= 1'b1;
        helper_mode_data <= mode;
        @(negedge clk);
        helper_mode_we   <= 1'b0;
        cur_helper = mode;
        mode_writes++;
    endtask

    function automatic logic [63:0] random_seed();
        logic [63:0] v;
        logic [15:0] low;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            2:
            begin
                low = v[63:48] ^ v[47:32] ^ v[31:16] ^ 16'($urandom_range(300));
                v   = {v[63:16], low};
            end
            3:
            begin
                v = 64'd1 << $urandom_range(63);
                if ($urandom_range(1))
                    v = ~v;
            end
            default: ;
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_mix.size() == 0)
                note_failure("unexpected result", 64'h0, mixed_value);
            else
            begin
                want = expected_mix.pop_front();
                if (mixed_value !== want)
                    note_failure("mixed_value mismatch", want, mixed_value);
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_pending)
            begin
                // hold off the output while requests keep arriving
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                pressure_pending = 1'b0;
            end
            else
                out_stall <= (!steady && $urandom_range(99) < 13);
        end
    end

    initial
    begin
        #400000;
        $display("fold_replace_mixer_test: done, errors");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        seed_value       = 64'h0;
        helper_mode_we   = 1'b0;
        helper_mode_data = 1'b0;
        cur_helper       = HELPER_IDENTITY;
        fail_count       = 0;
        items_taken      = 0;
        results_seen     = 0;
        mode_writes      = 0;
        steady           = 1'b0;
        pressure_pending = 1'b0;

        directed_rows = '{
            '{HELPER_IDENTITY, 64'h0000000000000000, 1'b1, 64'h0000000000000000},
            '{HELPER_IDENTITY, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'hFFFFFFFFFFFF0000},
            '{HELPER_IDENTITY, 64'h00000000000000FF, 1'b0, 64'h0},
            '{HELPER_IDENTITY, 64'h00000000000000FE, 1'b0, 64'h0},
            '{HELPER_IDENTITY, 64'h0000000000000100, 1'b0, 64'h0},
            '{HELPER_IDENTITY, 64'h8000000000000000, 1'b0, 64'h0},
            '{HELPER_IDENTITY, 64'h0001000100010001, 1'b0, 64'h0},
            '{HELPER_IDENTITY, 64'h123456789ABCDEF0, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h0000000000000000, 1'b1, 64'h0000000000000000},
            '{HELPER_CUBIC,    64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h0000000000000001, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h00000000000000FE, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h00000000000000FF, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h0000000000000100, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h8000000000000000, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h0001000100010001, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'hDEADBEEFCAFEF00D, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h00000000FFFFFFFF, 1'b0, 64'h0},
            '{HELPER_CUBIC,    64'h7FFFFFFFFFFFFFFF, 1'b0, 64'h0},
            '{HELPER_IDENTITY, 64'h5555555555555555, 1'b0, 64'h0},
            '{HELPER_IDENTITY, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0}
        };

        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        settle_and_select(HELPER_IDENTITY);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != cur_helper)
                settle_and_select(directed_rows[i].mode);
            send_seed(directed_rows[i].seed, directed_rows[i].known, directed_rows[i].result);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle_and_select((phase % 2 == 0) ? HELPER_CUBIC : HELPER_IDENTITY);
            steady = (phase == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 1 && k == 10)
                    pressure_pending = 1'b1;
                send_seed(random_seed(), 1'b0, 64'h0);
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8)
            @(posedge clk);
        while (expected_mix.size() != 0)
            note_failure("result never arrived", expected_mix.pop_front(), 64'h0);

        $display("covered %0d requests and %0d results over %0d helper mode writes",
                 items_taken, results_seen, mode_writes);
        $display("including fold-limit edges, wrapping cubic values and a long output hold");
        if (fail_count == 0)
            $display("fold_replace_mixer_test: done, clean");
        else
            $display("fold_replace_mixer_test: done, errors");
        $finish;
    end

endmodule
